[rtl/core/mffd_pkg.sv]
`default_nettype none
package mffd_pkg;

   localparam int BYTE_W      = 8;
   localparam int POS_W       = 5;
   localparam int PAYLOAD_LEN = 16;
   localparam int PAYLOAD_W   = PAYLOAD_LEN * BYTE_W;
   localparam int WORD_W      = 32;
   localparam int SCALE_SHIFT = 10;
   localparam int COARSE_W    = WORD_W - SCALE_SHIFT;
   localparam int OUT_W       = 22;
   localparam int SCALE_W     = 11;
   localparam int PROD_W      = COARSE_W + SCALE_W - 1;

   localparam logic [BYTE_W-1:0]  START_BYTE = 8'h3C;
   localparam logic [BYTE_W-1:0]  END_BYTE   = 8'h3E;
   localparam logic [POS_W-1:0]   POS_HUNT   = 5'd0;
   localparam logic [POS_W-1:0]   POS_END    = 5'd17;
   localparam logic signed [SCALE_W-1:0] SCALE_MUL = 11'sd1000;

   // words already shifted down by SCALE_SHIFT, waiting for the multiply
   typedef struct packed {
      logic signed [COARSE_W-1:0] x_position;
      logic signed [COARSE_W-1:0] x_speed;
      logic signed [COARSE_W-1:0] y_position;
      logic signed [COARSE_W-1:0] y_speed;
   } coarse_type;

endpackage
`default_nettype wire

[rtl/core/motor_feedback_frame_decoder.sv]
// Motor feedback frame decoder.
// req channel: one received link byte per word (req_valid / req_stall,
// req_rx_byte). The block hunts for '<', sixteen payload bytes, '>'.
// rsp channel: one word per good frame with four rescaled signed 22-bit
// fields (rsp_valid / rsp_stall). A bad end marker drops the frame silently.
// Throughput: one byte per cycle. req_stall only rises on the end-marker
// byte when the two-entry frame queue is full.
// Path: the edge that takes the end byte writes the frame queue; the
// multiply of the queue head is then registered into the output
// register, which a receiver stall can hold off.
// Reset (synchronous) empties the queue, drops the output word and returns
// to hunting for a start byte.
// While the receiver stalls, the output word holds, up to two further
// frames wait in the queue, and bytes keep flowing until a third frame
// reaches its end marker.
`default_nettype none
module motor_feedback_frame_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [mffd_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_x_position,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_x_speed,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_y_position,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_y_speed
);

   logic                 push;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;
   mffd_pkg::coarse_type push_data;
   mffd_pkg::coarse_type head_data;

   mffd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .push        (push),
      .push_data   (push_data),
      .queue_full  (queue_full)
   );

   mffd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   mffd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_position (rsp_x_position),
      .rsp_x_speed    (rsp_x_speed),
      .rsp_y_position (rsp_y_position),
      .rsp_y_speed    (rsp_y_speed)
   );

endmodule
`default_nettype wire

[rtl/core/mffd_front.sv]
`default_nettype none
module mffd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [mffd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                              push,
   output mffd_pkg::coarse_type              push_data,
   input  wire logic                         queue_full
);

   logic [mffd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [mffd_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                           accept;
   logic                           at_end;

   // end position (and anything past it) needs a queue slot
   assign at_end    = (pos_ff >= mffd_pkg::POS_END);
   assign req_stall = at_end && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && at_end && (req_rx_byte == mffd_pkg::END_BYTE);

   always_comb begin
      pos_in     = pos_ff;
      payload_in = payload_ff;
      if (accept) begin
         if (pos_ff == mffd_pkg::POS_HUNT) begin
            if (req_rx_byte == mffd_pkg::START_BYTE) begin
               pos_in = 5'd1;
            end
         end else if (!at_end) begin
            // first payload byte ends up in the lowest byte lane
            payload_in = {req_rx_byte, payload_ff[mffd_pkg::PAYLOAD_W-1:mffd_pkg::BYTE_W]};
            pos_in     = pos_ff + 5'd1;
         end else begin
            pos_in = mffd_pkg::POS_HUNT;
         end
      end
   end

   // arithmetic shift right by 10 is just dropping the low bits
   assign push_data.x_position = payload_ff[31:10];
   assign push_data.x_speed    = payload_ff[63:42];
   assign push_data.y_position = payload_ff[95:74];
   assign push_data.y_speed    = payload_ff[127:106];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= mffd_pkg::POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

endmodule
`default_nettype wire

[rtl/core/mffd_queue.sv]
`default_nettype none
module mffd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mffd_pkg::coarse_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output mffd_pkg::coarse_type      head_data
);

   mffd_pkg::coarse_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/mffd_back.sv]
`default_nettype none
module mffd_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               head_valid,
   input  wire mffd_pkg::coarse_type               head_data,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_x_position,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_x_speed,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_y_position,
   output logic signed [mffd_pkg::OUT_W-1:0]       rsp_y_speed
);

   logic                                   valid_ff, valid_in;
   logic signed [mffd_pkg::OUT_W-1:0]      xp_ff, xs_ff, yp_ff, ys_ff;
   logic signed [mffd_pkg::PROD_W-1:0]     xp_prod, xs_prod, yp_prod, ys_prod;

   function automatic logic signed [mffd_pkg::PROD_W-1:0] scale(
      input logic signed [mffd_pkg::COARSE_W-1:0] a
   );
      scale = mffd_pkg::PROD_W'(a) * mffd_pkg::PROD_W'(mffd_pkg::SCALE_MUL);
   endfunction

   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   assign xp_prod = scale(head_data.x_position);
   assign xs_prod = scale(head_data.x_speed);
   assign yp_prod = scale(head_data.y_position);
   assign ys_prod = scale(head_data.y_speed);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // product >>> 10, the top bits are the 22-bit result
   always_ff @(posedge clock) begin
      if (pop) begin
         xp_ff <= xp_prod[mffd_pkg::PROD_W-1:mffd_pkg::SCALE_SHIFT];
         xs_ff <= xs_prod[mffd_pkg::PROD_W-1:mffd_pkg::SCALE_SHIFT];
         yp_ff <= yp_prod[mffd_pkg::PROD_W-1:mffd_pkg::SCALE_SHIFT];
         ys_ff <= ys_prod[mffd_pkg::PROD_W-1:mffd_pkg::SCALE_SHIFT];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_x_position = xp_ff;
   assign rsp_x_speed    = xs_ff;
   assign rsp_y_position = yp_ff;
   assign rsp_y_speed    = ys_ff;

endmodule
`default_nettype wire

[verif/tb_motor_feedback_frame_decoder.sv]
`default_nettype none
module tb_motor_feedback_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int ITEM_TARGET    = 1150;
   localparam int HOLD_AT        = 300;
   localparam int DRAIN_AT       = 600;
   localparam int CALM_AT        = 950;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_FRAMES    = 8;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   class motor_frame_scoreboard;
      typedef struct {
         logic signed [mffd_pkg::OUT_W-1:0] x_position;
         logic signed [mffd_pkg::OUT_W-1:0] x_speed;
         logic signed [mffd_pkg::OUT_W-1:0] y_position;
         logic signed [mffd_pkg::OUT_W-1:0] y_speed;
      } motor_reading_type;

      logic [mffd_pkg::POS_W-1:0]  frame_pos = mffd_pkg::POS_HUNT;
      logic [mffd_pkg::BYTE_W-1:0] payload [mffd_pkg::PAYLOAD_LEN];
      motor_reading_type           pending_readings [$];
      int unsigned                 mismatches = 0;

      // floor(floor(v / 1024) * 1000 / 1024), kept to the output width
      function automatic logic signed [mffd_pkg::OUT_W-1:0] scaled_reading(
         int unsigned base);
         logic [mffd_pkg::WORD_W-1:0] raw;
         longint coarse;
         longint scaled;
         raw = {payload[base+3], payload[base+2], payload[base+1], payload[base]};
         coarse = longint'($signed(raw)) >>> mffd_pkg::SCALE_SHIFT;
         scaled = (coarse * longint'(mffd_pkg::SCALE_MUL)) >>> mffd_pkg::SCALE_SHIFT;
         return scaled[mffd_pkg::OUT_W-1:0];
      endfunction

      function void take_byte(logic [mffd_pkg::BYTE_W-1:0] rx);
         motor_reading_type r;
         if (frame_pos == mffd_pkg::POS_HUNT) begin
            if (rx == mffd_pkg::START_BYTE) frame_pos = 5'd1;
         end else if (frame_pos < mffd_pkg::POS_END) begin
            payload[4'(frame_pos - 5'd1)] = rx;
            frame_pos = frame_pos + 5'd1;
         end else begin
            // a bad end marker is never reused as a start byte
            frame_pos = mffd_pkg::POS_HUNT;
            if (rx == mffd_pkg::END_BYTE) begin
               r.x_position = scaled_reading(0);
               r.x_speed    = scaled_reading(4);
               r.y_position = scaled_reading(8);
               r.y_speed    = scaled_reading(12);
               pending_readings.push_back(r);
            end
         end
      endfunction

      function void compare_field(string field, logic signed [mffd_pkg::OUT_W-1:0] want,
                                  logic signed [mffd_pkg::OUT_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_word(logic signed [mffd_pkg::OUT_W-1:0] xp,
                               logic signed [mffd_pkg::OUT_W-1:0] xs,
                               logic signed [mffd_pkg::OUT_W-1:0] yp,
                               logic signed [mffd_pkg::OUT_W-1:0] ys);
         motor_reading_type r;
         if (pending_readings.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d",
                     $time, xp, xs, yp, ys);
            return;
         end
         r = pending_readings.pop_front();
         compare_field("x_position", r.x_position, xp);
         compare_field("x_speed", r.x_speed, xs);
         compare_field("y_position", r.y_position, yp);
         compare_field("y_speed", r.y_speed, ys);
      endfunction

      function int unsigned pending();
         return pending_readings.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [mffd_pkg::BYTE_W-1:0]       req_rx_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [mffd_pkg::OUT_W-1:0] rsp_x_position;
   logic signed [mffd_pkg::OUT_W-1:0] rsp_x_speed;
   logic signed [mffd_pkg::OUT_W-1:0] rsp_y_position;
   logic signed [mffd_pkg::OUT_W-1:0] rsp_y_speed;

   bit          long_hold = 1'b0;
   bit          no_idle = 1'b0;
   bit          back_to_back = 1'b0;
   int unsigned frame_bytes_sent = 0;
   int unsigned quiet_cycles = 0;

   motor_frame_scoreboard sb = new();

   motor_feedback_frame_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_position (rsp_x_position),
      .rsp_x_speed    (rsp_x_speed),
      .rsp_y_position (rsp_y_position),
      .rsp_y_speed    (rsp_y_speed)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.take_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_x_position, rsp_x_speed, rsp_y_position, rsp_y_speed);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, calm stretches, one long hold on request
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold = 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   task automatic idle_for(int unsigned n);
      @(negedge clock);
      req_valid = 1'b0;
      req_rx_byte = 8'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_byte(logic [mffd_pkg::BYTE_W-1:0] rx);
      @(negedge clock);
      req_valid = 1'b1;
      req_rx_byte = rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!no_idle && !back_to_back && $urandom_range(0, 9) == 0)
         idle_for($urandom_range(1, 13));
   endtask

   task automatic send_frame(logic [mffd_pkg::PAYLOAD_W-1:0] body,
                             logic [mffd_pkg::BYTE_W-1:0] tail);
      send_byte(mffd_pkg::START_BYTE);
      for (int i = 0; i < mffd_pkg::PAYLOAD_LEN; i++)
         send_byte(body[mffd_pkg::BYTE_W*i +: mffd_pkg::BYTE_W]);
      send_byte(tail);
      frame_bytes_sent += mffd_pkg::PAYLOAD_LEN + 2;
   endtask

   function automatic logic [mffd_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(0, 4095);
         4: return -$urandom_range(0, 4095);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [mffd_pkg::PAYLOAD_W-1:0] pick_body();
      return {pick_word(), pick_word(), pick_word(), pick_word()};
   endfunction

   function automatic logic [mffd_pkg::BYTE_W-1:0] pick_bad_tail();
      logic [mffd_pkg::BYTE_W-1:0] b;
      if ($urandom_range(0, 2) == 0) return mffd_pkg::START_BYTE;
      b = 8'($urandom);
      if (b == mffd_pkg::END_BYTE) b = ~b;
      return b;
   endfunction

   initial begin : req_side
      bit hold_done;
      bit drain_done;
      int unsigned k;
      logic [mffd_pkg::BYTE_W-1:0] noise;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: stray end marker, extreme words, bad end marker of '<',
      // payload holding both marker bytes and values around the shift boundary
      send_byte(mffd_pkg::END_BYTE);
      send_frame({32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                 mffd_pkg::END_BYTE);
      send_frame(pick_body(), mffd_pkg::START_BYTE);
      send_frame({32'h3E3C_3E3C, 32'hFFFF_FBFF, 32'hFFFF_FC00, 32'h0000_03FF},
                 mffd_pkg::END_BYTE);

      while (frame_bytes_sent < ITEM_TARGET) begin
         if (!hold_done && frame_bytes_sent >= HOLD_AT) begin
            // long receiver hold while frames keep coming: fills the queue
            hold_done = 1'b1;
            long_hold = 1'b1;
            back_to_back = 1'b1;
            repeat (HOLD_FRAMES) send_frame(pick_body(), mffd_pkg::END_BYTE);
            back_to_back = 1'b0;
         end
         if (!drain_done && frame_bytes_sent >= DRAIN_AT) begin
            drain_done = 1'b1;
            idle_for(1);
            while (sb.pending() != 0) @(posedge clock);
         end
         if (frame_bytes_sent >= CALM_AT) no_idle = 1'b1;

         case ($urandom_range(0, 9))
            0: send_frame(pick_body(), pick_bad_tail());
            1: begin
               k = $urandom_range(1, 4);
               repeat (k) begin
                  noise = 8'($urandom);
                  if (noise == mffd_pkg::START_BYTE) noise = mffd_pkg::END_BYTE;
                  send_byte(noise);
               end
               frame_bytes_sent += k;
            end
            2: begin
               // cut-off frame: the next frame's bytes land in its payload
               k = $urandom_range(1, mffd_pkg::PAYLOAD_LEN);
               send_byte(mffd_pkg::START_BYTE);
               repeat (k - 1) send_byte(8'($urandom));
               frame_bytes_sent += k;
            end
            default: send_frame(pick_body(), mffd_pkg::END_BYTE);
         endcase
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
